FILE: hdl/sfp_pkg.sv
`timescale 1ns / 1ps

package sfp_pkg;

	// Framing bytes of the feedback link.
	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] TRAILER     = 8'h7D;

	// Message type and command that mark a joint feedback body.
	localparam logic [7:0] JOINT_TYPE = 8'h01;
	localparam logic [7:0] JOINT_CMD  = 8'h06;

	// Number of angle fields on the result port.
	localparam int ANGLE_SLOTS = 6;

	typedef enum logic [2:0] {
		ST_JOINT    = 3'd0,
		ST_OTHER    = 3'd1,
		ST_FRAMING  = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_SHORT    = 3'd4,
		ST_TOO_LONG = 3'd5
	} status_t;

	typedef struct packed {
		status_t                         status;
		logic [7:0]                      msg_type;
		logic [7:0]                      command;
		logic [7:0]                      body_length;
		logic [ANGLE_SLOTS-1:0][15:0]    angle;
	} result_t;

endpackage

FILE: hdl/sfp_in_stage.sv
`timescale 1ns / 1ps

module sfp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// The stage takes a new beat when it is empty or its beat moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte register; it needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

FILE: hdl/sfp_parse_core.sv
`timescale 1ns / 1ps

module sfp_parse_core #(
	parameter int MAX_FRAME_BYTES = 255,
	parameter int JOINT_COUNT     = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	output logic             res_valid,
	output sfp_pkg::result_t result
);

	localparam logic [7:0] LEN_LIMIT     = 8'(MAX_FRAME_BYTES - 5);
	localparam logic [8:0] MIN_JOINT_LEN = 9'(2 + 2 * JOINT_COUNT);

	logic [7:0]  pos_q;
	logic        sync_ok_q;
	logic [7:0]  len_q;
	logic [7:0]  sum_q;
	logic [7:0]  type_q;
	logic [7:0]  cmd_q;
	logic [7:0]  csum_q;
	logic [15:0] angle_q [JOINT_COUNT];

	logic [8:0]  pos_w;
	logic [8:0]  body_end;
	logic        in_hunt;
	logic        in_sync2;
	logic        in_len;
	logic        in_body;
	logic        in_csum;
	logic        in_trailer;
	logic        too_long;
	logic        joint_ok;
	sfp_pkg::status_t trailer_status;
	logic [sfp_pkg::ANGLE_SLOTS-1:0][15:0] angle_out;

	// Phase of the frame from the byte position and the declared length.
	assign pos_w      = {1'b0, pos_q};
	assign body_end   = 9'd3 + {1'b0, len_q};
	assign in_hunt    = (pos_q == 8'd0);
	assign in_sync2   = (pos_q == 8'd1);
	assign in_len     = (pos_q == 8'd2);
	assign in_body    = (pos_q >= 8'd3) && (pos_w < body_end);
	assign in_csum    = (pos_q >= 8'd3) && (pos_w == body_end);
	assign in_trailer = (pos_q >= 8'd3) && (pos_w > body_end);
	assign too_long   = in_len && (byte_in > LEN_LIMIT);

	// Verdict on the trailer byte: framing errors win over the checksum.
	always_comb begin
		if (!sync_ok_q || byte_in != sfp_pkg::TRAILER) begin
			trailer_status = sfp_pkg::ST_FRAMING;
		end else if (sum_q != csum_q) begin
			trailer_status = sfp_pkg::ST_CHECKSUM;
		end else if (type_q == sfp_pkg::JOINT_TYPE && cmd_q == sfp_pkg::JOINT_CMD) begin
			if ({1'b0, len_q} < MIN_JOINT_LEN) begin
				trailer_status = sfp_pkg::ST_SHORT;
			end else begin
				trailer_status = sfp_pkg::ST_JOINT;
			end
		end else begin
			trailer_status = sfp_pkg::ST_OTHER;
		end
	end

	assign joint_ok  = in_trailer && (trailer_status == sfp_pkg::ST_JOINT);
	assign res_valid = step && (too_long || in_trailer);

	// Angles reach the result only for good joint frames; spare slots read zero.
	for (genvar e = 0; e < sfp_pkg::ANGLE_SLOTS; e++) begin : g_angle_out
		if (e < JOINT_COUNT) begin : g_used
			assign angle_out[e] = joint_ok ? angle_q[e] : 16'd0;
		end else begin : g_spare
			assign angle_out[e] = 16'd0;
		end
	end

	// Result assembled for the output register.
	always_comb begin
		result.status      = too_long ? sfp_pkg::ST_TOO_LONG : trailer_status;
		result.msg_type    = type_q;
		result.command     = cmd_q;
		result.body_length = in_len ? byte_in : len_q;
		result.angle       = angle_out;
	end

	// Frame state: position, sync flag, length, sum and header bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 8'd0;
			sync_ok_q <= 1'b0;
			len_q     <= 8'd0;
			sum_q     <= 8'd0;
			type_q    <= 8'd0;
			cmd_q     <= 8'd0;
			csum_q    <= 8'd0;
		end else if (step) begin
			if (in_hunt) begin
				if (byte_in == sfp_pkg::SYNC_FIRST) begin
					pos_q     <= 8'd1;
					sync_ok_q <= 1'b0;
					len_q     <= 8'd0;
					sum_q     <= 8'd0;
					type_q    <= 8'd0;
					cmd_q     <= 8'd0;
					csum_q    <= 8'd0;
				end
			end else if (in_sync2) begin
				sync_ok_q <= (byte_in == sfp_pkg::SYNC_SECOND);
				pos_q     <= 8'd2;
			end else if (in_len) begin
				len_q <= byte_in;
				pos_q <= too_long ? 8'd0 : 8'd3;
			end else if (in_body) begin
				sum_q <= sum_q + byte_in;
				if (pos_q == 8'd3) begin
					type_q <= byte_in;
				end
				if (pos_q == 8'd4) begin
					cmd_q <= byte_in;
				end
				pos_q <= pos_q + 8'd1;
			end else if (in_csum) begin
				csum_q <= byte_in;
				pos_q  <= pos_q + 8'd1;
			end else begin
				pos_q <= 8'd0;
			end
		end
	end

	// Angle bytes, little-endian, taken from the body after the header.
	for (genvar e = 0; e < JOINT_COUNT; e++) begin : g_angle_store
		always_ff @(posedge clk) begin
			if (step && in_body && pos_q == 8'(5 + 2 * e)) begin
				angle_q[e][7:0] <= byte_in;
			end
			if (step && in_body && pos_q == 8'(6 + 2 * e)) begin
				angle_q[e][15:8] <= byte_in;
			end
		end
	end

	// Every result ends the frame and sends the parser back to hunting.
	a_result_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> pos_q == 8'd0)
		else $error("parser did not return to hunting after a result");

	// A length that was not rejected fits the frame limit.
	a_length_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result.status != sfp_pkg::ST_TOO_LONG |-> result.body_length <= LEN_LIMIT)
		else $error("result carries a length above the limit");

	// The position never runs past the trailer of the declared frame.
	a_position_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q > 8'd2 |-> pos_w <= body_end + 9'd1)
		else $error("byte position ran past the trailer");

endmodule

FILE: hdl/sfp_out_stage.sv
`timescale 1ns / 1ps

module sfp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sfp_pkg::result_t result,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output sfp_pkg::result_t res_q
);

	// A new result may enter when the register is empty or being emptied.
	assign advance = !out_valid || out_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
		end
	end

	// Result payload; it needs no reset.
	always_ff @(posedge clk) begin
		if (load && advance) begin
			res_q <= result;
		end
	end

endmodule

FILE: hdl/servo_feedback_frame_parser.sv
`timescale 1ns / 1ps
// A byte accepted into the input register is parsed from there into the result register,
// where its result, if any, shows at out_valid.
// Throughput: one byte per cycle while out_ready is high; a waiting result stalls the input.
// Reset: arst_n clears the parser to hunting for sync, empties both registers, and
// sets rx_enable to 1. The angle store is not cleared; frames whose body reaches it refill it.

module servo_feedback_frame_parser #(
	parameter int MAX_FRAME_BYTES = 255,
	parameter int JOINT_COUNT     = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [7:0]         msg_type,
	output logic [7:0]         command,
	output logic [7:0]         body_length,
	output logic signed [15:0] angle_one,
	output logic signed [15:0] angle_two,
	output logic signed [15:0] angle_three,
	output logic signed [15:0] angle_four,
	output logic signed [15:0] angle_five,
	output logic signed [15:0] angle_six
);

	logic             rx_enable_q;
	logic             advance;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             step;
	logic             res_valid;
	sfp_pkg::result_t result;
	sfp_pkg::result_t res_q;

	// Port enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enable_q <= 1'b1;
		end else if (cfg_write) begin
			rx_enable_q <= cfg_data;
		end
	end

	sfp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// A byte in the input register is parsed when it moves on; a closed port drops it.
	assign step = valid_s1 && advance && rx_enable_q;

	sfp_parse_core #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.JOINT_COUNT     (JOINT_COUNT)
	) u_parse_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.res_valid (res_valid),
		.result    (result)
	);

	sfp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.result    (result),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// Result fields on their own ports.
	assign status      = res_q.status;
	assign msg_type    = res_q.msg_type;
	assign command     = res_q.command;
	assign body_length = res_q.body_length;
	assign angle_one   = signed'(res_q.angle[0]);
	assign angle_two   = signed'(res_q.angle[1]);
	assign angle_three = signed'(res_q.angle[2]);
	assign angle_four  = signed'(res_q.angle[3]);
	assign angle_five  = signed'(res_q.angle[4]);
	assign angle_six   = signed'(res_q.angle[5]);

	// The input side only stalls behind a result that is waiting to be taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// Angles are zero on every result other than joint feedback.
	a_angles_only_joint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != sfp_pkg::ST_JOINT |-> angle_one == 16'sd0 && angle_six == 16'sd0)
		else $error("angles present on a non-joint result");

	// A parsed byte with a result always finds the result register free.
	a_result_stored: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid)
		else $error("result was lost");

endmodule
